@@ rtl/fafr_pkg.sv @@
// ----------------------------------------------------------------------------
// fafr_pkg
// Shared types, codes and sizes for the fragment-assembling frame ring.
// ----------------------------------------------------------------------------
package fafr_pkg;

    // Ring geometry. FRAME_BYTES is a power of two so a slot base is a bit field.
    localparam int NUM_SLOTS   = 4;
    localparam int FRAME_BYTES = 65536;

    localparam int SLOT_W  = $clog2(NUM_SLOTS);
    localparam int OFF_W   = $clog2(FRAME_BYTES);
    localparam int FILL_W  = OFF_W + 1;
    localparam int LEN_W   = 17;
    localparam int SUM_W   = ((FILL_W > LEN_W) ? FILL_W : LEN_W) + 1;
    localparam int DEPTH   = NUM_SLOTS * FRAME_BYTES;
    localparam int ADDR_W  = SLOT_W + OFF_W;
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_READ   = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_RESET  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        FLAG_START  = 2'd0,
        FLAG_MIDDLE = 2'd1,
        FLAG_END    = 2'd2,
        FLAG_OTHER  = 2'd3
    } flag_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REJECT  = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    // One classified item on its way to the memory side.
    typedef struct packed {
        logic              mem_we;
        logic              mem_re;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
        status_t           status;
        logic [LEN_W-1:0]  frame_length;
        logic              frame_last;
    } op_t;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == '0)
            r = SLOT_W'(NUM_SLOTS - 1);
        else
            r = s - 1'b1;
        return r;
    endfunction

endpackage

@@ rtl/fragment_assembling_frame_ring.sv @@
// ----------------------------------------------------------------------------
// fragment_assembling_frame_ring
// Ring of frame slots filled from byte fragments and read back frame by frame.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while item_stall is low (the op queue is
// not full): the front resolves each item in its cycle against the per-slot
// fill and error flops, and the back makes at most one access to the single-port
// frame RAM per item. A result passes from the op queue through the RAM stage
// register to the output register. The frame RAM is not cleared after
// reset; reads only reach bytes that were written.
module fragment_assembling_frame_ring
    import fafr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  logic [1:0]       kind,
    input  logic [7:0]       data_byte,
    input  logic [LEN_W-1:0] fragment_length,
    input  logic             fragment_first,
    input  logic             fragment_last,
    input  logic [1:0]       frame_flag,
    output logic             result_valid,
    input  logic             result_stall,
    output logic [1:0]       status,
    output logic [7:0]       out_byte,
    output logic [LEN_W-1:0] frame_length,
    output logic             frame_last
);

    logic accept;
    logic push;
    op_t  push_op;
    logic q_full;
    logic q_not_empty;
    op_t  q_head;
    logic q_pop;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    fafr_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .kind            (kind),
        .data_byte       (data_byte),
        .fragment_length (fragment_length),
        .fragment_first  (fragment_first),
        .fragment_last   (fragment_last),
        .frame_flag      (frame_flag),
        .push            (push),
        .op              (push_op)
    );

    fafr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_op   (q_head)
    );

    fafr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .out_byte     (out_byte),
        .frame_length (frame_length),
        .frame_last   (frame_last)
    );

endmodule

@@ rtl/fafr_ram.sv @@
// ----------------------------------------------------------------------------
// fafr_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module fafr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (re)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/fafr_front.sv @@
// ----------------------------------------------------------------------------
// fafr_front
// Classifies each item against the slot bookkeeping and emits one memory op.
// ----------------------------------------------------------------------------
module fafr_front
    import fafr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [1:0]       kind,
    input  logic [7:0]       data_byte,
    input  logic [LEN_W-1:0] fragment_length,
    input  logic             fragment_first,
    input  logic             fragment_last,
    input  logic [1:0]       frame_flag,
    output logic             push,
    output op_t              op
);

    logic [FILL_W-1:0] fill_reg [NUM_SLOTS];
    logic              bad_reg  [NUM_SLOTS];
    logic [SLOT_W-1:0] ws_reg, ws_next;
    logic [SLOT_W-1:0] rs_reg, rs_next;
    logic [FILL_W-1:0] off_reg, off_next;
    logic              drop_reg, drop_next;

    kind_t             kind_e;
    flag_t             flag_e;
    logic [SLOT_W-1:0] idx;
    logic [FILL_W-1:0] cur_fill;
    logic              cur_bad;
    logic [SUM_W-1:0]  need;
    logic              drop_now;
    logic [FILL_W-1:0] off_inc;
    logic              fill_inc;
    logic              bad_set;
    logic              clear_en;
    logic [SLOT_W-1:0] clear_idx;
    logic              last_byte;

    assign kind_e   = kind_t'(kind);
    assign flag_e   = flag_t'(frame_flag);
    assign idx      = (kind_e == KIND_READ) ? rs_reg : ws_reg;
    assign cur_fill = fill_reg[idx];
    assign cur_bad  = bad_reg[idx];
    assign need     = SUM_W'(cur_fill) + SUM_W'(fragment_length);
    assign off_inc  = off_reg + 1'b1;

    always_comb
    begin
        ws_next   = ws_reg;
        rs_next   = rs_reg;
        off_next  = off_reg;
        drop_next = drop_reg;
        fill_inc  = 1'b0;
        bad_set   = 1'b0;
        clear_en  = 1'b0;
        clear_idx = ws_reg;
        last_byte = 1'b0;
        drop_now  = drop_reg;

        op.mem_we       = 1'b0;
        op.mem_re       = 1'b0;
        op.addr         = {ws_reg, cur_fill[OFF_W-1:0]};
        op.wdata        = data_byte;
        op.status       = ST_OK;
        op.frame_length = '0;
        op.frame_last   = 1'b0;

        case (kind_e)
            KIND_APPEND:
            begin
                if (fragment_first)
                    drop_now = (fragment_length == '0) || (need > SUM_W'(FRAME_BYTES));
                drop_next = drop_now & ~fragment_last;
                if (drop_now)
                    op.status = ST_REJECT;
                else if (flag_e == FLAG_OTHER)
                    op.status = ST_IGNORED;
                else
                begin
                    if (cur_fill < FILL_W'(FRAME_BYTES))
                    begin
                        op.mem_we = 1'b1;
                        fill_inc  = 1'b1;
                    end
                    else
                        op.status = ST_IGNORED;
                    // close the slot on the end byte of a frame
                    if (flag_e == FLAG_END && fragment_last)
                    begin
                        ws_next   = next_slot(ws_reg);
                        clear_en  = 1'b1;
                        clear_idx = ws_next;
                    end
                end
            end
            KIND_READ:
            begin
                if (rs_reg == ws_reg)
                    op.status = ST_EMPTY;
                else
                begin
                    op.frame_length = LEN_W'(cur_fill);
                    op.addr         = {rs_reg, off_reg[OFF_W-1:0]};
                    if (off_reg >= cur_fill)
                        last_byte = 1'b1;
                    else
                    begin
                        op.mem_re = ~cur_bad;
                        off_next  = off_inc;
                        last_byte = (off_inc >= cur_fill);
                    end
                    op.frame_last = last_byte;
                    if (last_byte)
                    begin
                        off_next = '0;
                        rs_next  = next_slot(rs_reg);
                    end
                end
            end
            KIND_ERROR:
            begin
                bad_set   = 1'b1;
                drop_next = 1'b0;
                ws_next   = next_slot(ws_reg);
                clear_en  = 1'b1;
                clear_idx = ws_next;
            end
            KIND_RESET:
            begin
                ws_next   = '0;
                rs_next   = '0;
                off_next  = '0;
                drop_next = 1'b0;
                clear_en  = 1'b1;
                clear_idx = '0;
            end
            default:
            begin
                op.status = ST_OK;
            end
        endcase
    end

    assign push = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg   <= '0;
            rs_reg   <= '0;
            off_reg  <= '0;
            drop_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                fill_reg[i] <= '0;
                bad_reg[i]  <= 1'b0;
            end
        end
        else if (accept)
        begin
            ws_reg   <= ws_next;
            rs_reg   <= rs_next;
            off_reg  <= off_next;
            drop_reg <= drop_next;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (clear_en && clear_idx == SLOT_W'(i))
                begin
                    fill_reg[i] <= '0;
                    bad_reg[i]  <= 1'b0;
                end
                else
                begin
                    if (fill_inc && ws_reg == SLOT_W'(i))
                        fill_reg[i] <= fill_reg[i] + 1'b1;
                    if (bad_set && ws_reg == SLOT_W'(i))
                        bad_reg[i] <= 1'b1;
                end
            end
        end
    end

endmodule

@@ rtl/fafr_queue.sv @@
// ----------------------------------------------------------------------------
// fafr_queue
// Short FIFO of classified ops between the front and the memory side.
// ----------------------------------------------------------------------------
module fafr_queue
    import fafr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output op_t  head_op
);

    op_t               entry_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full      = (cnt_reg == QCNT_W'(Q_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_op   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push && full |-> pop)
        else $error("push into full queue");

endmodule

@@ rtl/fafr_back.sv @@
// ----------------------------------------------------------------------------
// fafr_back
// Carries out at most one memory access per op and holds the result for the consumer.
// ----------------------------------------------------------------------------
module fafr_back
    import fafr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_not_empty,
    input  op_t              q_head,
    output logic             q_pop,
    output logic             result_valid,
    input  logic             result_stall,
    output logic [1:0]       status,
    output logic [7:0]       out_byte,
    output logic [LEN_W-1:0] frame_length,
    output logic             frame_last
);

    op_t               s1_reg;
    logic              s1_valid_reg;
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [7:0]        out_byte_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_last_reg;
    logic [7:0]        ram_rdata;
    logic              s1_move;
    logic              issue;

    // move the in-flight op on while the RAM output still holds its data
    assign s1_move = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign issue   = q_not_empty && (!s1_valid_reg || s1_move);
    assign q_pop   = issue;

    fafr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (issue && q_head.mem_we),
        .re    (issue && q_head.mem_re),
        .addr  (q_head.addr),
        .wdata (q_head.wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (issue)
            s1_reg <= q_head;
        if (s1_move)
        begin
            out_status_reg <= s1_reg.status;
            out_byte_reg   <= s1_reg.mem_re ? ram_rdata : 8'd0;
            out_len_reg    <= s1_reg.frame_length;
            out_last_reg   <= s1_reg.frame_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign out_byte     = out_byte_reg;
    assign frame_length = out_len_reg;
    assign frame_last   = out_last_reg;

    a_read_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_reg.mem_re |-> s1_reg.status == ST_OK)
        else $error("memory read on a non-ok op");

    a_issue_lands: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> s1_valid_reg)
        else $error("issued op lost");

    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ST_OK |-> !out_last_reg && out_byte_reg == 8'd0)
        else $error("non-ok result carries read fields");

endmodule

@@ sim/frame_ring_checker.sv @@
// ----------------------------------------------------------------------------
// frame_ring_checker
// Watches both channels of the frame ring, predicts the result of every
// accepted item from its own model of the slots and pointers, and compares
// each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module frame_ring_checker
    import fafr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_stall,
    input  logic [1:0]       kind,
    input  logic [7:0]       data_byte,
    input  logic [LEN_W-1:0] fragment_length,
    input  logic             fragment_first,
    input  logic             fragment_last,
    input  logic [1:0]       frame_flag,
    input  logic             result_valid,
    input  logic             result_stall,
    input  logic [1:0]       status,
    input  logic [7:0]       out_byte,
    input  logic [LEN_W-1:0] frame_length,
    input  logic             frame_last,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t          status;
        logic [7:0]       data;
        logic [LEN_W-1:0] length;
        logic             last;
    } ring_result_t;

    logic [7:0]        frame_mem [DEPTH];
    logic [FILL_W-1:0] fill [NUM_SLOTS];
    logic              bad [NUM_SLOTS];
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_slot;
    logic [FILL_W-1:0] rd_off;
    logic              dropping;
    ring_result_t      expected_results [$];
    ring_result_t      want;

    // The ring walks downward; slot 0 wraps to the top slot.
    function automatic logic [SLOT_W-1:0] ring_advance(input logic [SLOT_W-1:0] s);
        return (s == '0) ? SLOT_W'(NUM_SLOTS - 1) : s - 1'b1;
    endfunction

    function automatic void close_write_slot();
        wr_slot       = ring_advance(wr_slot);
        fill[wr_slot] = '0;
        bad[wr_slot]  = 1'b0;
    endfunction

    function automatic ring_result_t predict_ring_step(
        input kind_t            k,
        input logic [7:0]       d,
        input logic [LEN_W-1:0] len,
        input logic             first,
        input logic             last,
        input flag_t            flag
    );
        ring_result_t     r;
        logic [SUM_W-1:0] need;
        r = '0;
        case (k)
            KIND_APPEND:
            begin
                // Decide the fate of the whole fragment on its first byte.
                if (first)
                begin
                    need     = SUM_W'(fill[wr_slot]) + SUM_W'(len);
                    dropping = (len == '0) || (need > SUM_W'(FRAME_BYTES));
                end
                if (dropping)
                begin
                    if (last)
                        dropping = 1'b0;
                    r.status = ST_REJECT;
                end
                else if (flag == FLAG_OTHER)
                begin
                    r.status = ST_IGNORED;
                end
                else
                begin
                    if (fill[wr_slot] < FILL_W'(FRAME_BYTES))
                    begin
                        frame_mem[{wr_slot, fill[wr_slot][OFF_W-1:0]}] = d;
                        fill[wr_slot] = fill[wr_slot] + 1'b1;
                    end
                    else
                    begin
                        r.status = ST_IGNORED;
                    end
                    // A full slot still closes on an end byte.
                    if (flag == FLAG_END && last)
                        close_write_slot();
                end
            end
            KIND_READ:
            begin
                if (rd_slot == wr_slot)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.length = LEN_W'(fill[rd_slot]);
                    // Offset past the fill: zero-length or overrun frame, skip it.
                    if (rd_off >= fill[rd_slot])
                    begin
                        r.last = 1'b1;
                    end
                    else
                    begin
                        if (!bad[rd_slot])
                            r.data = frame_mem[{rd_slot, rd_off[OFF_W-1:0]}];
                        rd_off = rd_off + 1'b1;
                        r.last = (rd_off >= fill[rd_slot]);
                    end
                    if (r.last)
                    begin
                        rd_off  = '0;
                        rd_slot = ring_advance(rd_slot);
                    end
                end
            end
            KIND_ERROR:
            begin
                bad[wr_slot] = 1'b1;
                dropping     = 1'b0;
                close_write_slot();
            end
            KIND_RESET:
            begin
                wr_slot  = '0;
                rd_slot  = '0;
                rd_off   = '0;
                dropping = 1'b0;
                fill[0]  = '0;
                bad[0]   = 1'b0;
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                fill[i] = '0;
                bad[i]  = 1'b0;
            end
            wr_slot    = '0;
            rd_slot    = '0;
            rd_off     = '0;
            dropping   = 1'b0;
            fail_count = 0;
            expected_results.delete();
            pending    = 0;
        end
        else
        begin
            // Compare results first: a result never belongs to an item taken at the same edge.
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with nothing predicted: status %0d out_byte %0d",
                           status, out_byte);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %0d, got %0d", want.data, out_byte);
                        fail_count++;
                    end
                    if (frame_length !== want.length)
                    begin
                        $error("frame_length: expected %0d, got %0d", want.length,
                               frame_length);
                        fail_count++;
                    end
                    if (frame_last !== want.last)
                    begin
                        $error("frame_last: expected %0d, got %0d", want.last, frame_last);
                        fail_count++;
                    end
                end
            end
            if (item_valid && !item_stall)
                expected_results.push_back(predict_ring_step(kind_t'(kind), data_byte,
                    fragment_length, fragment_first, fragment_last, flag_t'(frame_flag)));
            pending = expected_results.size();
        end
    end

endmodule

@@ sim/tb_fragment_assembling_frame_ring.sv @@
// ----------------------------------------------------------------------------
// tb_fragment_assembling_frame_ring
// Drives the frame ring with directed cases and a long run of random fragment
// traffic, reads, error marks and ring resets, with random idling on both
// channels and one long output hold-off. Checking is done by
// frame_ring_checker.
// ----------------------------------------------------------------------------
module tb_fragment_assembling_frame_ring;
    timeunit 1ns;
    timeprecision 1ps;

    import fafr_pkg::*;

    localparam int RANDOM_ITEMS  = 1100;
    localparam int HOLD_CYCLES   = 200;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 20;

    logic             clk;
    logic             rst_n           = 1'b0;
    logic             item_valid      = 1'b0;
    logic             item_stall;
    logic [1:0]       kind            = '0;
    logic [7:0]       data_byte       = '0;
    logic [LEN_W-1:0] fragment_length = '0;
    logic             fragment_first  = 1'b0;
    logic             fragment_last   = 1'b0;
    logic [1:0]       frame_flag      = '0;
    logic             result_valid;
    logic             result_stall    = 1'b0;
    logic [1:0]       status;
    logic [7:0]       out_byte;
    logic [LEN_W-1:0] frame_length;
    logic             frame_last;

    int check_fails;
    int pending_results;
    int tx_gap_max  = 4;
    int rx_wait_max = 4;
    int sent_items  = 0;
    int idle_cycles = 0;
    bit long_hold   = 1'b0;

    fragment_assembling_frame_ring uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .kind            (kind),
        .data_byte       (data_byte),
        .fragment_length (fragment_length),
        .fragment_first  (fragment_first),
        .fragment_last   (fragment_last),
        .frame_flag      (frame_flag),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .status          (status),
        .out_byte        (out_byte),
        .frame_length    (frame_length),
        .frame_last      (frame_last)
    );

    frame_ring_checker ring_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .kind            (kind),
        .data_byte       (data_byte),
        .fragment_length (fragment_length),
        .fragment_first  (fragment_first),
        .fragment_last   (fragment_last),
        .frame_flag      (frame_flag),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .status          (status),
        .out_byte        (out_byte),
        .frame_length    (frame_length),
        .frame_last      (frame_last),
        .fail_count      (check_fails),
        .pending         (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result channel a random number of cycles before each transfer.
    initial
    begin : result_sink
        int wait_cycles;
        wait (rst_n);
        forever
        begin
            wait_cycles = long_hold ? HOLD_CYCLES : $urandom_range(0, rx_wait_max);
            long_hold   = 1'b0;
            if (wait_cycles > 0)
            begin
                result_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
                result_stall <= 1'b0;
            end
            @(posedge clk);
            while (!result_valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_item(
        input kind_t            k,
        input logic [7:0]       d,
        input logic [LEN_W-1:0] len,
        input logic             first,
        input logic             last,
        input flag_t            flag
    );
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        kind            <= k;
        data_byte       <= d;
        fragment_length <= len;
        fragment_first  <= first;
        fragment_last   <= last;
        frame_flag      <= flag;
        item_valid      <= 1'b1;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        sent_items++;
    endtask

    // One fragment of random bytes; the last byte carries the end flag when it closes the frame.
    task automatic send_fragment(
        input int               nbytes,
        input logic [LEN_W-1:0] claimed,
        input flag_t            head,
        input logic             closes
    );
        flag_t fl;
        for (int i = 0; i < nbytes; i++)
        begin
            if (closes && i == nbytes - 1)
                fl = FLAG_END;
            else if (i == 0)
                fl = head;
            else
                fl = FLAG_MIDDLE;
            send_item(KIND_APPEND, 8'($urandom), claimed, i == 0, i == nbytes - 1, fl);
        end
    endtask

    // Reads ignore every other field, so fill them with noise.
    task automatic read_burst(input int count);
        for (int i = 0; i < count; i++)
            send_item(KIND_READ, 8'($urandom), LEN_W'($urandom), 1'($urandom),
                      1'($urandom), flag_t'(2'($urandom)));
    endtask

    initial
    begin : stimulus
        int   pick;
        int   nfrag;
        int   nbytes;
        int   random_start;
        bit   hold_done;
        logic [LEN_W-1:0] claimed;

        hold_done = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Read from an empty ring.
        send_item(KIND_READ, 8'h00, '0, 1'b0, 1'b0, FLAG_START);
        // Three-byte frame with the data extremes.
        send_item(KIND_APPEND, 8'h00, 17'd3, 1'b1, 1'b0, FLAG_START);
        send_item(KIND_APPEND, 8'hFF, 17'd3, 1'b0, 1'b0, FLAG_MIDDLE);
        send_item(KIND_APPEND, 8'hA5, 17'd3, 1'b0, 1'b1, FLAG_END);
        // Zero-length fragment: dropped, and its end byte closes nothing.
        send_item(KIND_APPEND, 8'h11, '0, 1'b1, 1'b0, FLAG_START);
        send_item(KIND_APPEND, 8'h22, '0, 1'b0, 1'b1, FLAG_END);
        // Largest length field, then one byte over the slot size.
        send_item(KIND_APPEND, 8'h33, '1, 1'b1, 1'b1, FLAG_END);
        send_item(KIND_APPEND, 8'h44, LEN_W'(FRAME_BYTES + 1), 1'b1, 1'b1, FLAG_END);
        // Other flag on an opening byte that fits: that byte is ignored, the end byte is stored and closes the frame.
        send_item(KIND_APPEND, 8'h55, 17'd2, 1'b1, 1'b0, FLAG_OTHER);
        send_item(KIND_APPEND, 8'h66, 17'd2, 1'b0, 1'b1, FLAG_END);
        // Error mark on a partly written frame, then on an empty slot.
        send_item(KIND_APPEND, 8'h77, 17'd4, 1'b1, 1'b0, FLAG_START);
        send_item(KIND_APPEND, 8'h88, 17'd4, 1'b0, 1'b1, FLAG_MIDDLE);
        send_item(KIND_ERROR, 8'h00, '0, 1'b0, 1'b0, FLAG_START);
        send_item(KIND_ERROR, 8'h00, '0, 1'b0, 1'b0, FLAG_START);
        // The four slot closes wrap the write slot back onto the read slot, so every read here sees an empty ring.
        read_burst(8);
        // Ring reset with a closed frame still unread.
        send_item(KIND_APPEND, 8'h99, 17'd1, 1'b1, 1'b1, FLAG_END);
        send_item(KIND_RESET, 8'h00, '0, 1'b0, 1'b0, FLAG_START);
        send_item(KIND_READ, 8'h00, '0, 1'b0, 1'b0, FLAG_START);

        random_start = sent_items;
        while (sent_items < random_start + RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 39) == 0)
                tx_gap_max = (tx_gap_max != 0) ? 0 : 4;
            if ($urandom_range(0, 39) == 0)
                rx_wait_max = (rx_wait_max != 0) ? 0 : 4;
            // Hold the output off once while input keeps coming.
            if (!hold_done && sent_items >= random_start + RANDOM_ITEMS / 2)
            begin
                long_hold = 1'b1;
                hold_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                nfrag = $urandom_range(1, 3);
                for (int f = 0; f < nfrag; f++)
                begin
                    nbytes  = $urandom_range(1, 6);
                    claimed = LEN_W'(nbytes);
                    if ($urandom_range(0, 19) == 0)
                        claimed = LEN_W'($urandom);
                    send_fragment(nbytes, claimed, (f == 0) ? FLAG_START : FLAG_MIDDLE,
                                  f == nfrag - 1);
                end
            end
            else if (pick < 80)
            begin
                read_burst($urandom_range(1, 8));
            end
            else if (pick < 85)
            begin
                send_item(KIND_ERROR, 8'($urandom), LEN_W'($urandom), 1'($urandom),
                          1'($urandom), flag_t'(2'($urandom)));
            end
            else if (pick < 88)
            begin
                send_item(KIND_RESET, 8'($urandom), LEN_W'($urandom), 1'($urandom),
                          1'($urandom), flag_t'(2'($urandom)));
            end
            else
            begin
                send_item(kind_t'(2'($urandom)), 8'($urandom), LEN_W'($urandom),
                          1'($urandom), 1'($urandom), flag_t'(2'($urandom)));
            end
        end
        item_valid <= 1'b0;

        while (pending_results != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (check_fails == 0 && pending_results == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
rtl/fafr_pkg.sv
rtl/fafr_ram.sv
rtl/fafr_front.sv
rtl/fafr_queue.sv
rtl/fafr_back.sv
rtl/fragment_assembling_frame_ring.sv
sim/frame_ring_checker.sv
sim/tb_fragment_assembling_frame_ring.sv
